// ===== src/exact_match_rule_table_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the exact-match rule table
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef EXACT_MATCH_RULE_TABLE_DEFINES_SVH
`define EXACT_MATCH_RULE_TABLE_DEFINES_SVH

// Same-cycle implication: when trig holds, cons holds on the same edge
`define EMRT_ASSERT_IMPL(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when trig holds, cons holds on the following edge
`define EMRT_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/emrt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rule table package
// Types, codes and sizes shared by the rule cells and the table control.
// ---------------------------------------------------------------------------
package emrt_pkg;

   localparam int unsigned MAX_RULES_DEFAULT = 32;
   localparam int unsigned ADDR_W            = 32;
   localparam int unsigned HITS_W            = 32;
   localparam int unsigned COUNT_FIELD_W     = 6;
   localparam logic [1:0]  VERDICT_MAX       = 2'd1;

   // Operation codes carried in the request tuser
   typedef enum logic [2:0] {
      ACT_ADD      = 3'd0,
      ACT_DELETE   = 3'd1,
      ACT_CLEAR    = 3'd2,
      ACT_MATCH    = 3'd3,
      ACT_SNAPSHOT = 3'd4
   } action_type;

   // Result status codes
   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_INVALID   = 3'd1,
      STAT_DUPLICATE = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   // Control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_SNAP = 2'd2
   } state_type;

   // One stored rule
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              verdict;
      logic              enable;
      logic [HITS_W-1:0] hits;
   } entry_type;

   // Per-cell command from the table control
   typedef struct packed {
      logic compare_en;
      logic load_new;
      logic take_next;
      logic take_head;
      logic bump;
   } cell_ctrl_type;

endpackage

// ===== src/exact_match_rule_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Exact-match rule table
// Ordered table of source-address rules kept in a chain of rule cells.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per transfer: add, delete, clear, match or
//   snapshot. rsp_* returns the results; every operation yields one result
//   with rsp_tlast set, except a snapshot of n rules, which yields n results
//   in table order with the last one marked.
//   Timing: a request is taken in the idle state, every cell compares its
//   address against the request address on that same edge, and the execute
//   step picks the first hit and updates the chain. A result is loaded into
//   the output register when its operation executes, and no new request is
//   accepted until the last one has executed. A snapshot streams one rule a
//   cycle while the receiver takes them, by rotating the chain through cell 0;
//   its rules follow the execute step, and requests wait for the last one.
//   The output register decouples the sides: a request is taken while a
//   result still waits. When the receiver stalls, the operation holds in its
//   execute step and the chain does not change until the result is taken.
//   Reset empties the table at once; rule contents are not cleared.
// ---------------------------------------------------------------------------
`include "exact_match_rule_table_defines.svh"

module exact_match_rule_table #(
   parameter int unsigned MAX_RULES = emrt_pkg::MAX_RULES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request: source_address[31:0], rule_verdict[33:32], rule_enabled[34], zero[39:35]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // request: action[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // response: out_address[31:0], out_verdict[32], out_enabled[33], out_hits[65:34],
   //           table_count[71:66]
   output logic [71:0] rsp_tdata,
   // response: status[2:0], entry_valid[3]
   output logic [3:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);
   localparam int unsigned ENTRY_W = $bits(emrt_pkg::entry_type);

   // Sequencer and table state
   emrt_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         snap_ptr_ff, snap_ptr_in;

   // Latched operation
   emrt_pkg::action_type     op_action_ff;
   logic [emrt_pkg::ADDR_W-1:0] op_address_ff;
   logic [1:0]               op_verdict_ff;
   logic                     op_enabled_ff;

   // Output register
   logic                     rsp_valid_ff, rsp_valid_in;
   emrt_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic                     rsp_entry_valid_ff, rsp_entry_valid_in;
   emrt_pkg::entry_type      rsp_entry_ff, rsp_entry_in;
   logic [emrt_pkg::COUNT_FIELD_W-1:0] rsp_count_ff;
   logic                     rsp_last_ff, rsp_last_in;

   // Cell chain
   emrt_pkg::entry_type      cell_entry [MAX_RULES];
   emrt_pkg::cell_ctrl_type  cell_ctrl  [MAX_RULES];
   logic [MAX_RULES-1:0]     cell_match;
   logic [MAX_RULES-1:0]     cell_enable;
   emrt_pkg::entry_type      new_entry;

   // Control decode
   logic                     req_accept;
   logic                     out_free;
   logic                     exec_go;
   logic                     snap_go;
   logic                     snap_last;
   logic [MAX_RULES-1:0]     occ;
   logic [MAX_RULES-1:0]     occ_next;
   logic [MAX_RULES-1:0]     tail;
   logic [MAX_RULES-1:0]     addr_hit;
   logic [MAX_RULES-1:0]     en_hit;
   logic [MAX_RULES-1:0]     addr_first;
   logic [MAX_RULES-1:0]     en_first;
   logic [MAX_RULES-1:0]     del_mask;
   logic [ENTRY_W-1:0]       sel_bits;
   emrt_pkg::entry_type      sel_entry;
   logic                     do_load;
   logic                     do_delete;
   logic                     do_bump;
   logic                     do_rotate;
   logic                     table_full;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign snap_last  = (snap_ptr_ff == count_ff - CNT_W'(1));

   // Occupancy, tail and hit vectors
   always_comb begin
      for (int i = 0; i < MAX_RULES; i++) begin
         occ[i]         = (CNT_W'(i) < count_ff);
         tail[i]        = (CNT_W'(i) == count_ff);
         cell_enable[i] = cell_entry[i].enable;
      end
   end

   generate
      if (MAX_RULES > 1) begin : g_occ_next
         assign occ_next = {1'b0, occ[MAX_RULES-1:1]};
      end else begin : g_occ_single
         assign occ_next = '0;
      end
   endgenerate

   assign addr_hit   = cell_match & occ;
   assign en_hit     = addr_hit & cell_enable;
   assign addr_first = addr_hit & (~addr_hit + MAX_RULES'(1));
   assign en_first   = en_hit & (~en_hit + MAX_RULES'(1));
   assign del_mask   = ~(addr_first - MAX_RULES'(1)) & occ_next;
   assign table_full = (count_ff >= CNT_W'(MAX_RULES));

   // Read the first enabled hit out of the chain
   always_comb begin
      sel_bits = '0;
      for (int i = 0; i < MAX_RULES; i++) begin
         sel_bits = sel_bits | (cell_entry[i] & {ENTRY_W{en_first[i]}});
      end
      sel_entry = emrt_pkg::entry_type'(sel_bits);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         emrt_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = emrt_pkg::ST_EXEC;
            end
         end
         emrt_pkg::ST_EXEC: begin
            if (out_free) begin
               if (op_action_ff == emrt_pkg::ACT_SNAPSHOT && count_ff != '0) begin
                  state_in = emrt_pkg::ST_SNAP;
               end else begin
                  state_in = emrt_pkg::ST_IDLE;
               end
            end
         end
         emrt_pkg::ST_SNAP: begin
            if (out_free && snap_last) begin
               state_in = emrt_pkg::ST_IDLE;
            end
         end
         default: state_in = emrt_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      exec_go    = 1'b0;
      snap_go    = 1'b0;
      unique case (state_ff)
         emrt_pkg::ST_IDLE: req_tready = 1'b1;
         emrt_pkg::ST_EXEC: exec_go    = out_free;
         emrt_pkg::ST_SNAP: snap_go    = out_free;
         default: begin
         end
      endcase
   end

   // Execute the operation and build its result
   always_comb begin
      count_in           = count_ff;
      snap_ptr_in        = snap_ptr_ff;
      do_load            = 1'b0;
      do_delete          = 1'b0;
      do_bump            = 1'b0;
      do_rotate          = 1'b0;
      rsp_status_in      = emrt_pkg::STAT_OK;
      rsp_entry_valid_in = 1'b0;
      rsp_entry_in       = '0;
      rsp_last_in        = 1'b1;
      if (exec_go) begin
         snap_ptr_in = '0;
         case (op_action_ff)
            emrt_pkg::ACT_ADD: begin
               if (op_verdict_ff > emrt_pkg::VERDICT_MAX) begin
                  rsp_status_in = emrt_pkg::STAT_INVALID;
               end else if (|addr_hit) begin
                  rsp_status_in = emrt_pkg::STAT_DUPLICATE;
               end else if (table_full) begin
                  rsp_status_in = emrt_pkg::STAT_FULL;
               end else begin
                  do_load  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            emrt_pkg::ACT_DELETE: begin
               if (|addr_hit) begin
                  do_delete = 1'b1;
                  count_in  = count_ff - CNT_W'(1);
               end else begin
                  rsp_status_in = emrt_pkg::STAT_NOT_FOUND;
               end
            end
            emrt_pkg::ACT_CLEAR: begin
               count_in = '0;
            end
            emrt_pkg::ACT_MATCH: begin
               if (|en_hit) begin
                  do_bump            = 1'b1;
                  rsp_entry_valid_in = 1'b1;
                  rsp_entry_in       = sel_entry;
                  rsp_entry_in.hits  = sel_entry.hits + emrt_pkg::HITS_W'(1);
               end else begin
                  rsp_status_in = emrt_pkg::STAT_NOT_FOUND;
               end
            end
            emrt_pkg::ACT_SNAPSHOT: begin
               // an empty table gives one empty result; otherwise stream later
            end
            default: begin
               rsp_status_in = emrt_pkg::STAT_INVALID;
            end
         endcase
      end else if (snap_go) begin
         do_rotate          = 1'b1;
         rsp_entry_valid_in = 1'b1;
         rsp_entry_in       = cell_entry[0];
         rsp_last_in        = snap_last;
         snap_ptr_in        = snap_ptr_ff + CNT_W'(1);
      end
   end

   // A result lands on execute (not a non-empty snapshot) and with each snapshot rule
   assign rsp_valid_in = ((exec_go && !(op_action_ff == emrt_pkg::ACT_SNAPSHOT &&
                                        count_ff != '0)) || snap_go) ||
                         (rsp_valid_ff && !rsp_tready);

   assign new_entry = '{address: op_address_ff, verdict: op_verdict_ff[0],
                        enable: op_enabled_ff, hits: '0};

   // Cell chain: each cell hands its rule to the left neighbor on shifts
   generate
      for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
         emrt_pkg::entry_type next_src;
         if (g + 1 < MAX_RULES) begin : g_link
            assign next_src = cell_entry[g+1];
         end else begin : g_end
            assign next_src = cell_entry[g];
         end

         assign cell_ctrl[g] = '{
            compare_en: req_accept,
            load_new:   do_load && tail[g],
            take_next:  (do_delete && del_mask[g]) || (do_rotate && occ_next[g]),
            take_head:  do_rotate && occ[g] && !occ_next[g],
            bump:       do_bump && en_first[g]
         };

         emrt_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl[g]),
            .key        (req_tdata[emrt_pkg::ADDR_W-1:0]),
            .new_entry  (new_entry),
            .next_entry (next_src),
            .head_entry (cell_entry[0]),
            .entry      (cell_entry[g]),
            .match      (cell_match[g])
         );
      end
   endgenerate

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= emrt_pkg::ST_IDLE;
         count_ff     <= '0;
         snap_ptr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         snap_ptr_ff  <= snap_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Latch the operation on transfer; load the result when it is produced
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_action_ff  <= emrt_pkg::action_type'(req_tuser);
         op_address_ff <= req_tdata[emrt_pkg::ADDR_W-1:0];
         op_verdict_ff <= req_tdata[33:32];
         op_enabled_ff <= req_tdata[34];
      end
      if (exec_go || snap_go) begin
         rsp_status_ff      <= rsp_status_in;
         rsp_entry_valid_ff <= rsp_entry_valid_in;
         rsp_entry_ff       <= rsp_entry_in;
         rsp_count_ff       <= emrt_pkg::COUNT_FIELD_W'(count_in);
         rsp_last_ff        <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_entry_ff.hits, rsp_entry_ff.enable,
                        rsp_entry_ff.verdict, rsp_entry_ff.address};
   assign rsp_tuser  = {rsp_entry_valid_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `EMRT_ASSERT_NEXT(a_accept_exec, req_accept, state_ff == emrt_pkg::ST_EXEC, "transfer not followed by execute")
   `EMRT_ASSERT_IMPL(a_nonlast_snap, rsp_valid_ff && !rsp_last_ff, state_ff == emrt_pkg::ST_SNAP, "unmarked result outside snapshot")
   `EMRT_ASSERT_IMPL(a_entry_ok, rsp_valid_ff && rsp_entry_valid_ff, rsp_status_ff == emrt_pkg::STAT_OK, "rule carried with bad status")
   `EMRT_ASSERT_NEXT(a_idle_count, state_ff == emrt_pkg::ST_IDLE, count_ff == $past(count_ff), "rule count moved while idle")

endmodule

// ===== src/emrt_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rule cell
// Holds one rule, compares it against the search key, counts its hits and takes a new rule,
// its right-hand neighbor or the head of the chain on command.
// ---------------------------------------------------------------------------
module emrt_cell (
   input  logic                              clock,
   input  emrt_pkg::cell_ctrl_type           ctrl,
   input  logic [emrt_pkg::ADDR_W-1:0]       key,
   input  emrt_pkg::entry_type               new_entry,
   input  emrt_pkg::entry_type               next_entry,
   input  emrt_pkg::entry_type               head_entry,
   output emrt_pkg::entry_type               entry,
   output logic                              match
);

   emrt_pkg::entry_type entry_ff;
   emrt_pkg::entry_type entry_in;
   logic                match_ff;

   // Select the next contents of the cell
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load_new) begin
         entry_in = new_entry;
      end else if (ctrl.take_next) begin
         entry_in = next_entry;
      end else if (ctrl.take_head) begin
         entry_in = head_entry;
      end
      if (ctrl.bump) begin
         entry_in.hits = entry_ff.hits + emrt_pkg::HITS_W'(1);
      end
   end

   // Hold the rule and the address compare taken at the transfer
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctrl.compare_en) begin
         match_ff <= (entry_ff.address == key);
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule
